// File: rtl/core/ptri_pkg.sv
// shared types, constants and the arctangent table for the range image projection
// used by every module under rtl/core; depends on nothing
package ptri_pkg;

    localparam int IMAGE_ROWS = 64;
    localparam int IMAGE_COLS = 256;
    localparam int ROW_W = 6;
    localparam int COL_W = 8;
    localparam int ROW_QB = $clog2(IMAGE_ROWS);
    localparam int COL_QB = $clog2(IMAGE_COLS);
    localparam int DIV_STEPS = (ROW_QB > COL_QB) ? ROW_QB : COL_QB;
    localparam int SQRT_STEPS = 32;
    localparam int CORDIC_STEPS = 20;

    localparam int CRD_W = 52;
    localparam int ACC_W = 25;
    localparam int REM_W = 24;
    localparam int DVS_W = 20;
    localparam int SH_W = 32;

    localparam logic signed [ACC_W-1:0] PI_Q20 = 25'sd3294199;

    localparam logic [16:0] ELEV_TOP_RST = 17'd51472;
    localparam logic [16:0] ELEV_STEP_RST = 17'd1634;
    localparam logic [18:0] AZIM_STEP_RST = 19'd1608;
    localparam logic [12:0] DEPTH_SCALE_RST = 13'd512;

    typedef enum logic [1:0] {
        CFG_ELEV_TOP    = 2'd0,
        CFG_ELEV_STEP   = 2'd1,
        CFG_AZIM_STEP   = 2'd2,
        CFG_DEPTH_SCALE = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] root;
    } t_sqrt;

    typedef struct packed {
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic signed [ACC_W-1:0] acc;
    } t_cordic;

    typedef struct packed {
        logic [REM_W-1:0]     rem;
        logic [DIV_STEPS-1:0] q;
    } t_div;

    typedef struct packed {
        logic valid;
        logic keep;
        logic azero;
    } t_ctl;

    // atan(2^-i) in rad * 2^20, rounded
    function automatic logic signed [ACC_W-1:0] atan_q20(input logic [4:0] i);
        logic signed [ACC_W-1:0] v;
        case (i)
            5'd0:    v = 25'sd823550;
            5'd1:    v = 25'sd486170;
            5'd2:    v = 25'sd256879;
            5'd3:    v = 25'sd130396;
            5'd4:    v = 25'sd65451;
            5'd5:    v = 25'sd32757;
            5'd6:    v = 25'sd16383;
            5'd7:    v = 25'sd8192;
            5'd8:    v = 25'sd4096;
            5'd9:    v = 25'sd2048;
            5'd10:   v = 25'sd1024;
            5'd11:   v = 25'sd512;
            5'd12:   v = 25'sd256;
            5'd13:   v = 25'sd128;
            5'd14:   v = 25'sd64;
            5'd15:   v = 25'sd32;
            5'd16:   v = 25'sd16;
            5'd17:   v = 25'sd8;
            5'd18:   v = 25'sd4;
            5'd19:   v = 25'sd2;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/point_to_range_image_projection.sv
// top level: lidar point to range image pixel projection pipeline
// depends on ptri_pkg, ptri_sqrt_cell, ptri_cordic_cell, ptri_div_cell

// One point is taken per clock (start high while busy low) and exactly one
// result follows, flagged by o_strobe for a single cycle; the
// receiver cannot stall, so every result must be captured in that cycle. A
// dropped point (zero tag, point at origin, row or column off the image) still
// gives a result, with o_write_valid and all fields at zero. The latency is set
// by the cell chains: 32 square root cells, 20 cordic cells for elevation, and
// 8 division cells for row and column, plus setup and output stages. The azimuth
// cordic runs alongside the square root. busy is high only during reset and the
// cycle after. Configuration writes are taken whenever busy is low and must only
// be made while no point is in flight.
module point_to_range_image_projection (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [23:0] i_x_coord,
    input  logic [23:0] i_y_coord,
    input  logic [23:0] i_z_coord,
    input  logic [23:0] i_return_tag,
    output logic        o_strobe,
    output logic        o_write_valid,
    output logic [5:0]  o_pixel_row,
    output logic [7:0]  o_pixel_col,
    output logic [15:0] o_depth_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [18:0] i_cfg_data
);

    localparam int S = ptri_pkg::SQRT_STEPS;
    localparam int C = ptri_pkg::CORDIC_STEPS;
    localparam int D = ptri_pkg::DIV_STEPS;
    // stages from point transfer to result
    localparam int LATENCY = 2 + S + C + 3 + D + 2;
    // control runs from the setup stage to the division input
    localparam int CTL_N = S + C + 2;
    // azimuth waits for the elevation path
    localparam int AZ_N = S - C + C;
    localparam int R_N = C + 3 + D;

    // configuration registers
    logic        r_busy;
    logic [16:0] r_elev_top;
    logic [16:0] r_elev_step;
    logic [18:0] r_azim_step;
    logic [12:0] r_depth_scale;
    logic        w_cfg_wr;

    assign busy = r_busy;
    assign o_cfg_ready = !r_busy;
    assign w_cfg_wr = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_elev_top <= ptri_pkg::ELEV_TOP_RST;
            r_elev_step <= ptri_pkg::ELEV_STEP_RST;
            r_azim_step <= ptri_pkg::AZIM_STEP_RST;
            r_depth_scale <= ptri_pkg::DEPTH_SCALE_RST;
        end else begin
            r_busy <= 1'b0;
            if (w_cfg_wr) begin
                case (ptri_pkg::t_cfg_idx'(i_cfg_index))
                    ptri_pkg::CFG_ELEV_TOP:    r_elev_top <= i_cfg_data[16:0];
                    ptri_pkg::CFG_ELEV_STEP:   r_elev_step <= i_cfg_data[16:0];
                    ptri_pkg::CFG_AZIM_STEP:   r_azim_step <= i_cfg_data;
                    ptri_pkg::CFG_DEPTH_SCALE: r_depth_scale <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
        end
    end

    // zero step acts as one; divisors are twice the step
    logic [16:0] w_erow_step;
    logic [18:0] w_ecol_step;
    logic [ptri_pkg::DVS_W-1:0] w_div_r;
    logic [ptri_pkg::DVS_W-1:0] w_div_c;

    assign w_erow_step = (r_elev_step == 17'd0) ? 17'd1 : r_elev_step;
    assign w_ecol_step = (r_azim_step == 19'd0) ? 19'd1 : r_azim_step;
    assign w_div_r = {2'b00, w_erow_step, 1'b0};
    assign w_div_c = {w_ecol_step, 1'b0};

    // stage 0: capture the point
    logic        r_v0;
    logic        r_keep0;
    logic signed [23:0] r_x0;
    logic signed [23:0] r_y0;
    logic signed [23:0] r_z0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start && !busy;
        end
        r_keep0 <= (i_return_tag != 24'd0);
        r_x0 <= i_x_coord;
        r_y0 <= i_y_coord;
        r_z0 <= i_z_coord;
    end

    // stage 1: squares
    logic        r_v1;
    logic        r_keep1;
    logic [46:0] r_sx2;
    logic [46:0] r_sy2;
    logic [46:0] r_sz2;
    logic signed [23:0] r_x1;
    logic signed [23:0] r_y1;
    logic signed [23:0] r_z1;
    logic signed [47:0] w_px;
    logic signed [47:0] w_py;
    logic signed [47:0] w_pz;

    assign w_px = r_x0 * r_x0;
    assign w_py = r_y0 * r_y0;
    assign w_pz = r_z0 * r_z0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_v0;
        end
        r_keep1 <= r_keep0;
        r_sx2 <= w_px[46:0];
        r_sy2 <= w_py[46:0];
        r_sz2 <= w_pz[46:0];
        r_x1 <= r_x0;
        r_y1 <= r_y0;
        r_z1 <= r_z0;
    end

    // stage 2: sums, azimuth setup
    logic [47:0] w_hsq;
    logic [48:0] w_tot;
    logic signed [24:0] w_xv;
    logic signed [ptri_pkg::CRD_W-1:0] w_xs;
    logic signed [ptri_pkg::CRD_W-1:0] w_ys;
    ptri_pkg::t_cordic w_az0;
    ptri_pkg::t_ctl w_ctl0;

    assign w_hsq = {1'b0, r_sx2} + {1'b0, r_sy2};
    assign w_tot = {1'b0, w_hsq} + {2'b00, r_sz2};
    // azimuth is atan2(y, -x)
    assign w_xv = -{r_x1[23], r_x1};
    assign w_xs = {{11{w_xv[24]}}, w_xv, 16'd0};
    assign w_ys = {{12{r_y1[23]}}, r_y1, 16'd0};

    always_comb begin
        if (w_xv < 0) begin
            // left half plane: mirror and start from plus or minus pi
            w_az0.x = -w_xs;
            w_az0.y = -w_ys;
            w_az0.acc = (r_y1 >= 0) ? ptri_pkg::PI_Q20 : -ptri_pkg::PI_Q20;
        end else begin
            w_az0.x = w_xs;
            w_az0.y = w_ys;
            w_az0.acc = '0;
        end
        w_ctl0.valid = r_v1;
        w_ctl0.keep = r_keep1 && (w_tot != 49'd0);
        w_ctl0.azero = (r_x1 == 24'sd0) && (r_y1 == 24'sd0);
    end

    ptri_pkg::t_sqrt   r_sh_in;
    ptri_pkg::t_sqrt   r_st_in;
    ptri_pkg::t_cordic r_az_in;
    ptri_pkg::t_ctl    r_ctl [0:CTL_N];
    logic signed [23:0] r_zd [0:S];

    always_ff @(posedge i_clk) begin
        r_sh_in.rem <= {w_hsq, 16'd0};
        r_sh_in.root <= '0;
        r_st_in.rem <= {15'd0, w_tot};
        r_st_in.root <= '0;
        r_az_in <= w_az0;
        r_zd[0] <= r_z1;
        for (int j = 1; j <= S; j++) begin
            r_zd[j] <= r_zd[j-1];
        end
    end

    // control line, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= CTL_N; j++) begin
                r_ctl[j] <= '0;
            end
        end else begin
            r_ctl[0] <= w_ctl0;
            for (int j = 1; j <= CTL_N; j++) begin
                r_ctl[j] <= r_ctl[j-1];
            end
        end
    end

    // square root chains: horizontal range (scaled) and full range
    ptri_pkg::t_sqrt w_sh [0:S];
    ptri_pkg::t_sqrt w_st [0:S];

    assign w_sh[0] = r_sh_in;
    assign w_st[0] = r_st_in;

    for (genvar j = 0; j < S; j++) begin : g_sqrt
        ptri_sqrt_cell u_h (
            .i_clk (i_clk),
            .i_k   (5'(S - 1 - j)),
            .i_d   (w_sh[j]),
            .o_d   (w_sh[j+1])
        );
        ptri_sqrt_cell u_t (
            .i_clk (i_clk),
            .i_k   (5'(S - 1 - j)),
            .i_d   (w_st[j]),
            .o_d   (w_st[j+1])
        );
    end

    // azimuth cordic runs next to the square root
    ptri_pkg::t_cordic w_az [0:C];

    assign w_az[0] = r_az_in;

    for (genvar j = 0; j < C; j++) begin : g_az
        ptri_cordic_cell u_c (
            .i_clk (i_clk),
            .i_i   (5'(j)),
            .i_d   (w_az[j]),
            .o_d   (w_az[j+1])
        );
    end

    // elevation cordic: atan2(z * 256, hr), both scaled by 2^16
    ptri_pkg::t_cordic w_el [0:C];

    always_comb begin
        w_el[0].x = {4'd0, w_sh[S].root, 16'd0};
        w_el[0].y = {{4{r_zd[S][23]}}, r_zd[S], 24'd0};
        w_el[0].acc = '0;
    end

    for (genvar j = 0; j < C; j++) begin : g_el
        ptri_cordic_cell u_c (
            .i_clk (i_clk),
            .i_i   (5'(j)),
            .i_d   (w_el[j]),
            .o_d   (w_el[j+1])
        );
    end

    // azimuth angle and range wait for the elevation path
    logic signed [ptri_pkg::ACC_W-1:0] r_ad [0:AZ_N-1];
    logic [23:0] r_rd [0:R_N-1];

    always_ff @(posedge i_clk) begin
        r_ad[0] <= w_az[C].acc;
        for (int j = 1; j < AZ_N; j++) begin
            r_ad[j] <= r_ad[j-1];
        end
        r_rd[0] <= w_st[S].root[23:0];
        for (int j = 1; j < R_N; j++) begin
            r_rd[j] <= r_rd[j-1];
        end
    end

    // angle stage: rad * 2^20 to rad * 2^16, rounded
    ptri_pkg::t_ctl w_ctl_e;
    logic signed [ptri_pkg::ACC_W-1:0] w_azacc;
    logic signed [ptri_pkg::ACC_W-1:0] w_asum;
    logic signed [ptri_pkg::ACC_W-1:0] w_esum;
    logic signed [20:0] r_e16;
    logic signed [20:0] r_a16;

    assign w_ctl_e = r_ctl[S + C];
    // a zero vector has angle zero before the pi offset
    assign w_azacc = w_ctl_e.azero ? '0 : r_ad[AZ_N-1];
    assign w_asum = (w_azacc + ptri_pkg::PI_Q20 + 25'sd8) >>> 4;
    assign w_esum = ($signed(w_el[C].acc) + 25'sd8) >>> 4;

    always_ff @(posedge i_clk) begin
        r_e16 <= w_esum[20:0];
        r_a16 <= w_asum[20:0];
    end

    // doubled numerator plus step, so the quotient carries the half
    logic signed [23:0] r_n2r;
    logic signed [23:0] r_n2c;

    always_ff @(posedge i_clk) begin
        r_n2r <= $signed({6'd0, r_elev_top, 1'b0}) - $signed({{2{r_e16[20]}}, r_e16, 1'b0})
            + $signed({7'd0, w_erow_step});
        r_n2c <= $signed({{2{r_a16[20]}}, r_a16, 1'b0}) + $signed({5'd0, w_ecol_step});
    end

    // magnitude and range check ahead of the division chains
    logic        w_negr;
    logic        w_negc;
    logic [23:0] w_mr;
    logic [23:0] w_mc;
    logic [ptri_pkg::SH_W-1:0] w_limr;
    logic [ptri_pkg::SH_W-1:0] w_limc;
    logic        w_dropr;
    logic        w_dropc;
    ptri_pkg::t_ctl r_ctl2 [0:D];
    ptri_pkg::t_div r_dr_in;
    ptri_pkg::t_div r_dc_in;

    assign w_negr = r_n2r[23];
    assign w_negc = r_n2c[23];
    assign w_mr = w_negr ? 24'(-r_n2r) : r_n2r;
    assign w_mc = w_negc ? 24'(-r_n2c) : r_n2c;
    // a negative quotient survives only when it truncates to zero
    assign w_limr = w_negr ? {12'd0, w_div_r} : ({12'd0, w_div_r} << ptri_pkg::ROW_QB);
    assign w_limc = w_negc ? {12'd0, w_div_c} : ({12'd0, w_div_c} << ptri_pkg::COL_QB);
    assign w_dropr = {8'd0, w_mr} >= w_limr;
    assign w_dropc = {8'd0, w_mc} >= w_limc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= D; j++) begin
                r_ctl2[j] <= '0;
            end
        end else begin
            r_ctl2[0].valid <= r_ctl[CTL_N].valid;
            r_ctl2[0].keep <= r_ctl[CTL_N].keep && !w_dropr && !w_dropc;
            r_ctl2[0].azero <= r_ctl[CTL_N].azero;
            for (int j = 1; j <= D; j++) begin
                r_ctl2[j] <= r_ctl2[j-1];
            end
        end
        r_dr_in.rem <= w_mr;
        r_dr_in.q <= '0;
        r_dc_in.rem <= w_mc;
        r_dc_in.q <= '0;
    end

    // division chains for row and column
    ptri_pkg::t_div w_dr [0:D];
    ptri_pkg::t_div w_dc [0:D];

    assign w_dr[0] = r_dr_in;
    assign w_dc[0] = r_dc_in;

    for (genvar j = 0; j < D; j++) begin : g_div
        ptri_div_cell u_r (
            .i_clk (i_clk),
            .i_k   (4'(D - 1 - j)),
            .i_div (w_div_r),
            .i_d   (w_dr[j]),
            .o_d   (w_dr[j+1])
        );
        ptri_div_cell u_c (
            .i_clk (i_clk),
            .i_k   (4'(D - 1 - j)),
            .i_div (w_div_c),
            .i_d   (w_dc[j]),
            .o_d   (w_dc[j+1])
        );
    end

    // output stage: bounds, depth scaling with saturation
    logic [36:0] w_prod;
    logic [15:0] w_depth;
    logic        w_keep;
    logic        r_strobe;
    logic        r_wv;
    logic [5:0]  r_row;
    logic [7:0]  r_col;
    logic [15:0] r_depth;

    assign w_prod = {13'd0, r_rd[R_N-1]} * {24'd0, r_depth_scale};
    assign w_depth = (|w_prod[36:26]) ? 16'hFFFF : w_prod[25:10];
    assign w_keep = r_ctl2[D].keep
        && ({{(32-D){1'b0}}, w_dr[D].q} < 32'(ptri_pkg::IMAGE_ROWS))
        && ({{(32-D){1'b0}}, w_dc[D].q} < 32'(ptri_pkg::IMAGE_COLS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_wv <= 1'b0;
        end else begin
            r_strobe <= r_ctl2[D].valid;
            r_wv <= r_ctl2[D].valid && w_keep;
        end
        r_row <= w_keep ? w_dr[D].q[ptri_pkg::ROW_W-1:0] : '0;
        r_col <= w_keep ? w_dc[D].q[ptri_pkg::COL_W-1:0] : '0;
        r_depth <= w_keep ? w_depth : '0;
    end

    assign o_strobe = r_strobe;
    assign o_write_valid = r_wv;
    assign o_pixel_row = r_row;
    assign o_pixel_col = r_col;
    assign o_depth_value = r_depth;

`ifndef SYNTH
    // every transfer yields a result at the expected latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("result missing at expected latency");

    // a dropped point carries all zero fields
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_write_valid) |->
            (o_pixel_row == 6'd0 && o_pixel_col == 8'd0 && o_depth_value == 16'd0))
        else $error("dropped point with nonzero fields");

    // a pixel write only comes with the strobe
    a_wv_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_write_valid |-> o_strobe)
        else $error("pixel write without strobe");
`endif

endmodule

// File: rtl/core/ptri_sqrt_cell.sv
// one bit of a restoring integer square root, registered
// depends on ptri_pkg
module ptri_sqrt_cell (
    input  logic             i_clk,
    input  logic [4:0]       i_k,
    input  ptri_pkg::t_sqrt  i_d,
    output ptri_pkg::t_sqrt  o_d
);

    logic [65:0] w_term;
    logic [65:0] w_rem;
    ptri_pkg::t_sqrt n_d;
    ptri_pkg::t_sqrt r_d;

    // (root + 2^k)^2 - root^2
    assign w_term = ({34'd0, i_d.root} << ({1'b0, i_k} + 6'd1)) + (66'd1 << {i_k, 1'b0});
    assign w_rem = {2'b00, i_d.rem};

    always_comb begin
        n_d = i_d;
        if (w_rem >= w_term) begin
            n_d.rem = 64'(w_rem - w_term);
            n_d.root = i_d.root | (32'd1 << i_k);
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_d = r_d;

endmodule

// File: rtl/core/ptri_cordic_cell.sv
// one vectoring rotation of a cordic arctangent, registered
// depends on ptri_pkg
module ptri_cordic_cell (
    input  logic               i_clk,
    input  logic [4:0]         i_i,
    input  ptri_pkg::t_cordic  i_d,
    output ptri_pkg::t_cordic  o_d
);

    logic signed [ptri_pkg::CRD_W-1:0] w_dx;
    logic signed [ptri_pkg::CRD_W-1:0] w_dy;
    logic signed [ptri_pkg::ACC_W-1:0] w_ang;
    ptri_pkg::t_cordic n_d;
    ptri_pkg::t_cordic r_d;

    assign w_dx = $signed(i_d.x) >>> i_i;
    assign w_dy = $signed(i_d.y) >>> i_i;
    assign w_ang = ptri_pkg::atan_q20(i_i);

    always_comb begin
        if ($signed(i_d.y) > 0) begin
            n_d.x = $signed(i_d.x) + w_dy;
            n_d.y = $signed(i_d.y) - w_dx;
            n_d.acc = $signed(i_d.acc) + w_ang;
        end else begin
            n_d.x = $signed(i_d.x) - w_dy;
            n_d.y = $signed(i_d.y) + w_dx;
            n_d.acc = $signed(i_d.acc) - w_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_d = r_d;

endmodule

// File: rtl/core/ptri_div_cell.sv
// one quotient bit of a restoring division, registered
// depends on ptri_pkg
module ptri_div_cell (
    input  logic                        i_clk,
    input  logic [3:0]                  i_k,
    input  logic [ptri_pkg::DVS_W-1:0]  i_div,
    input  ptri_pkg::t_div              i_d,
    output ptri_pkg::t_div              o_d
);

    logic [ptri_pkg::SH_W-1:0] w_sh;
    logic [ptri_pkg::SH_W-1:0] w_rem;
    ptri_pkg::t_div n_d;
    ptri_pkg::t_div r_d;

    assign w_sh = {{(ptri_pkg::SH_W-ptri_pkg::DVS_W){1'b0}}, i_div} << i_k;
    assign w_rem = {{(ptri_pkg::SH_W-ptri_pkg::REM_W){1'b0}}, i_d.rem};

    always_comb begin
        n_d = i_d;
        if (w_rem >= w_sh) begin
            n_d.rem = ptri_pkg::REM_W'(w_rem - w_sh);
            n_d.q = i_d.q | (ptri_pkg::DIV_STEPS'(1) << i_k);
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_d = r_d;

endmodule
